### rtl/ntc_med_pkg.sv
// shared widths, register indexes and fixed-point constants of the ntc median temperature core
`default_nettype none

package ntc_med_pkg;

    // stream and configuration port widths
    localparam int SAMPLE_W   = 12;
    localparam int S_TDATA_W  = 16;
    localparam int TEMP_W     = 15;
    localparam int OFFSET_W   = 10;
    localparam int LIMIT_W    = 10;
    localparam int CODE_W     = 2;
    localparam int PERIOD_W   = 7;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic signed [TEMP_W-1:0] t_temp;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NTC_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HIGH  = 2'd2;

    // configuration reset values
    localparam logic [LIMIT_W-1:0] FREQ_LOW_RESET  = 10'd370;
    localparam logic [LIMIT_W-1:0] FREQ_HIGH_RESET = 10'd390;

    // frequency codes and matching timer periods
    localparam logic [CODE_W-1:0]   FREQ_1M50      = 2'd0;
    localparam logic [CODE_W-1:0]   FREQ_1M25      = 2'd1;
    localparam logic [CODE_W-1:0]   FREQ_1M00      = 2'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_1M50    = 7'd47;
    localparam logic [PERIOD_W-1:0] PERIOD_1M25    = 7'd57;
    localparam logic [PERIOD_W-1:0] PERIOD_1M00    = 7'd71;

    // sensor limits
    localparam logic [15:0] FAULT_CODE  = 16'd3800;
    localparam logic [13:0] PULLUP_OHMS = 14'd10000;
    localparam t_temp       FAULT_TEMP  = 15'sd800;
    localparam t_temp       ZERO_R_TEMP = -15'sd2731;

    // shared restoring divider
    localparam int DIV_NW     = 60;
    localparam int DIV_DW     = 48;
    localparam int DIV_CNT_W  = 6;

    // logarithm unit
    localparam int LOG_FRAC_W = 58;
    localparam int SQ_ITERS   = 58;
    localparam int ITER_W     = 6;
    localparam int LN_W       = 48;
    localparam logic [31:0] LN_REF_ARG = 32'd10000;
    localparam logic [31:0] LN2_HI     = 32'hB17217F7;
    localparam logic [31:0] LN2_LO     = 32'hD1CF79AC;
    localparam logic [63:0] LN_ROUND   = 64'd32768;

    // beta term 3380 * 0.003354 in q42, and 67600 in q42 as divider numerator
    localparam logic [LN_W-1:0] BETA_K =
        48'(((64'd1133652 << 42) + 64'd50000) / 64'd100000);
    localparam logic [DIV_NW-1:0] TEMP_NUM = 60'(64'd67600 << 42);

    // twice 273.15 kelvin in tenths
    localparam logic [15:0] HALF_N = 16'd5463;

endpackage

`default_nettype wire

### rtl/ntc_median_temperature_core.sv
// ntc thermistor temperature core: sample memory, median search, log and divide sequencer
//
//  channel   | dir | transfer when              | payload
//  s_axis    | in  | tvalid & tready            | tdata[11:0] adc_sample
//  m_axis    | out | tvalid & tready            | tdata sensor/final/code/period, tuser fault
//  cfg       | in  | valid & ready (always set) | index 0 offset, 1 low limit, 2 high limit
//
//  samples are stored one per cycle while the core is idle; the transfer after SAMPLE_COUNT stored
//  samples starts a computation, dominated by two log2 passes of 58 squarings on the shared
//  32x32 multiplier and two restoring divisions. s_axis is held off while computing.
//  synchronous active-low reset clears control state and configuration.
//  a result waiting on m_axis does not stall sample storing, only the next hand-over.
`default_nettype none

module ntc_median_temperature_core
    import ntc_med_pkg::*;
#(
    parameter int SAMPLE_COUNT = 10,
    parameter int ADC_BITS     = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input sample stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [11:0] adc_sample
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [14:0] sensor_temp, [29:15] final_temp,
                                                    // [31:30] freq_code, [38:32] timer_period
    output logic                  o_m_axis_tuser,   // [0] sensor_fault
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W    = $clog2(SAMPLE_COUNT);
    localparam int CNT_W    = $clog2(SAMPLE_COUNT + 1);
    localparam int MED_RANK = (SAMPLE_COUNT - 1) / 2;
    localparam int PROD_W   = ADC_BITS + 14;
    localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};

    // sequencer states
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_MED_CAND  = 5'd1;
    localparam logic [4:0] S_MED_LOAD  = 5'd2;
    localparam logic [4:0] S_MED_SCAN  = 5'd3;
    localparam logic [4:0] S_MED_CHECK = 5'd4;
    localparam logic [4:0] S_RANGE     = 5'd5;
    localparam logic [4:0] S_DIV       = 5'd6;
    localparam logic [4:0] S_RES       = 5'd7;
    localparam logic [4:0] S_NORM      = 5'd8;
    localparam logic [4:0] S_SQ0       = 5'd9;
    localparam logic [4:0] S_SQ1       = 5'd10;
    localparam logic [4:0] S_SQ2       = 5'd11;
    localparam logic [4:0] S_SQ3       = 5'd12;
    localparam logic [4:0] S_LN0       = 5'd13;
    localparam logic [4:0] S_LN1       = 5'd14;
    localparam logic [4:0] S_LN2       = 5'd15;
    localparam logic [4:0] S_LN3       = 5'd16;
    localparam logic [4:0] S_LN4       = 5'd17;
    localparam logic [4:0] S_LN5       = 5'd18;
    localparam logic [4:0] S_TEMP      = 5'd19;
    localparam logic [4:0] S_OUT       = 5'd20;

    // control registers
    logic [4:0]                r_state;
    logic [4:0]                n_state;
    logic [CNT_W-1:0]          r_count;
    logic                      r_out_valid;
    logic signed [OFFSET_W-1:0] r_offset;
    logic [LIMIT_W-1:0]        r_low;
    logic [LIMIT_W-1:0]        r_high;

    // sample memory
    logic [ADC_BITS-1:0]       r_mem [SAMPLE_COUNT];
    logic [ADC_BITS-1:0]       r_rd_data;
    logic [IDX_W-1:0]          w_rd_addr;

    // median search
    logic [IDX_W-1:0]          r_i;
    logic [IDX_W-1:0]          r_j;
    logic [IDX_W-1:0]          r_rank;
    logic [ADC_BITS-1:0]       r_cand;

    // divider
    logic [DIV_NW-1:0]         r_dq;
    logic [DIV_DW-1:0]         r_rem;
    logic [DIV_DW-1:0]         r_den;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic                      r_div_temp;

    // logarithm
    logic [31:0]               r_res;
    logic [31:0]               r_arg;
    logic [4:0]                r_k;
    logic [62:0]               r_y;
    logic [LOG_FRAC_W-1:0]     r_frac;
    logic [ITER_W-1:0]         r_iter;
    logic [63:0]               r_p;
    logic [127:0]              r_acc;
    logic                      r_ln_sensor;
    logic [LN_W-1:0]           r_c;

    // result
    t_temp                     r_sensor;
    logic                      r_fault;
    t_temp                     r_out_sensor;
    t_temp                     r_out_final;
    logic [CODE_W-1:0]         r_out_code;
    logic [PERIOD_W-1:0]       r_out_period;
    logic                      r_out_fault;

    // combinational helpers
    logic                      w_s_xfer;
    logic                      w_store;
    logic [ADC_BITS-1:0]       w_sample;
    logic                      w_less;
    logic                      w_scan_last;
    logic                      w_rank_hit;
    logic                      w_fault;
    logic [PROD_W-1:0]         w_prod;
    logic [DIV_DW:0]           w_div_t;
    logic                      w_div_ge;
    logic                      w_div_last;
    logic [31:0]               w_mul_a;
    logic [31:0]               w_mul_b;
    logic [127:0]              w_sq_sum;
    logic [63:0]               w_ny;
    logic                      w_sq_last;
    logic [62:0]               w_lq;
    logic [63:0]               w_ln_hi;
    logic [LN_W-1:0]           w_ln;
    logic [15:0]               w_n;
    logic [15:0]               w_nc;
    logic [15:0]               w_up;
    logic [15:0]               w_dn;
    t_temp                     w_temp;
    t_temp                     w_final;
    logic signed [15:0]        w_cur16;
    logic signed [15:0]        w_low16;
    logic signed [15:0]        w_high16;
    logic [CODE_W-1:0]         w_code;
    logic [PERIOD_W-1:0]       w_period;
    logic                      w_out_free;

    // handshakes
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_s_xfer        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_store         = (r_count < CNT_W'(SAMPLE_COUNT));
    assign w_sample        = ADC_BITS'(i_s_axis_tdata[SAMPLE_W-1:0]);
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // median rank: smaller values, and equal values at lower addresses
    assign w_less      = (r_rd_data < r_cand) || ((r_rd_data == r_cand) && (r_j < r_i));
    assign w_scan_last = (r_j == IDX_W'(SAMPLE_COUNT - 1));
    assign w_rank_hit  = (r_rank == IDX_W'(MED_RANK));

    // range check and divider operand for the resistance
    assign w_fault = (16'(r_cand) >= FAULT_CODE) || (r_cand == ADC_FULL);
    assign w_prod  = PROD_W'(r_cand) * PROD_W'(PULLUP_OHMS);

    // one restoring divider step
    assign w_div_t    = {r_rem, r_dq[DIV_NW-1]};
    assign w_div_ge   = (w_div_t >= {1'b0, r_den});
    assign w_div_last = (r_div_cnt == DIV_CNT_W'(DIV_NW - 1));

    // log2 operand: integer part then fraction
    assign w_lq = {5'd31 - r_k, r_frac};

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_SQ0: begin
                w_mul_a = r_y[31:0];
                w_mul_b = r_y[31:0];
            end
            S_SQ1: begin
                w_mul_a = r_y[31:0];
                w_mul_b = {1'b0, r_y[62:32]};
            end
            S_SQ2: begin
                w_mul_a = {1'b0, r_y[62:32]};
                w_mul_b = {1'b0, r_y[62:32]};
            end
            S_LN0: begin
                w_mul_a = w_lq[31:0];
                w_mul_b = LN2_LO;
            end
            S_LN1: begin
                w_mul_a = w_lq[31:0];
                w_mul_b = LN2_HI;
            end
            S_LN2: begin
                w_mul_a = {1'b0, w_lq[62:32]};
                w_mul_b = LN2_LO;
            end
            S_LN3: begin
                w_mul_a = {1'b0, w_lq[62:32]};
                w_mul_b = LN2_HI;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // squaring step: keep the q62 window and pull out one fraction bit
    assign w_sq_sum  = r_acc + (128'(r_p) << 64);
    assign w_ny      = w_sq_sum[125:62];
    assign w_sq_last = (r_iter == ITER_W'(SQ_ITERS - 1));

    // natural log in q42, rounded from q58
    assign w_ln_hi = r_acc[127:64] + LN_ROUND;
    assign w_ln    = LN_W'(w_ln_hi >> 16);

    // temperature from the quotient, truncated toward zero
    assign w_n    = r_dq[15:0];
    assign w_nc   = w_n + 16'(r_rem != '0);
    assign w_up   = w_n - HALF_N;
    assign w_dn   = HALF_N - w_nc;
    assign w_temp = (w_n >= HALF_N) ? $signed(w_up[15:1]) : $signed(15'd0 - w_dn[15:1]);

    // offset and frequency choice
    assign w_final  = r_fault ? FAULT_TEMP : t_temp'(r_sensor + TEMP_W'(r_offset));
    assign w_cur16  = 16'(w_final);
    assign w_low16  = $signed({6'd0, r_low});
    assign w_high16 = $signed({6'd0, r_high});

    always_comb begin
        priority if (w_cur16 < w_low16) begin
            w_code   = FREQ_1M50;
            w_period = PERIOD_1M50;
        end else if (w_cur16 < w_high16) begin
            w_code   = FREQ_1M25;
            w_period = PERIOD_1M25;
        end else begin
            w_code   = FREQ_1M00;
            w_period = PERIOD_1M00;
        end
    end

    // memory read address
    always_comb begin
        priority if (r_state == S_MED_CAND) begin
            w_rd_addr = r_i;
        end else if ((r_state == S_MED_SCAN) && !w_scan_last) begin
            w_rd_addr = r_j + 1'b1;
        end else begin
            w_rd_addr = '0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_xfer && !w_store) n_state = S_MED_CAND;
            end
            S_MED_CAND:  n_state = S_MED_LOAD;
            S_MED_LOAD:  n_state = S_MED_SCAN;
            S_MED_SCAN: begin
                if (w_scan_last) n_state = S_MED_CHECK;
            end
            S_MED_CHECK: n_state = w_rank_hit ? S_RANGE : S_MED_CAND;
            S_RANGE:     n_state = w_fault ? S_OUT : S_DIV;
            S_DIV: begin
                if (w_div_last) n_state = r_div_temp ? S_TEMP : S_RES;
            end
            S_RES:       n_state = (r_dq[31:0] == '0) ? S_OUT : S_NORM;
            S_NORM: begin
                if (r_arg[31]) n_state = S_SQ0;
            end
            S_SQ0:       n_state = S_SQ1;
            S_SQ1:       n_state = S_SQ2;
            S_SQ2:       n_state = S_SQ3;
            S_SQ3:       n_state = w_sq_last ? S_LN0 : S_SQ0;
            S_LN0:       n_state = S_LN1;
            S_LN1:       n_state = S_LN2;
            S_LN2:       n_state = S_LN3;
            S_LN3:       n_state = S_LN4;
            S_LN4:       n_state = S_LN5;
            S_LN5:       n_state = r_ln_sensor ? S_DIV : S_NORM;
            S_TEMP:      n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_offset    <= '0;
            r_low       <= FREQ_LOW_RESET;
            r_high      <= FREQ_HIGH_RESET;
        end else begin
            r_state <= n_state;
            if (w_s_xfer) begin
                r_count <= w_store ? r_count + 1'b1 : '0;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NTC_OFFSET: r_offset <= $signed(i_cfg_data);
                    CFG_FREQ_LOW:   r_low    <= i_cfg_data;
                    CFG_FREQ_HIGH:  r_high   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // sample memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_s_xfer && w_store) begin
            r_mem[r_count[IDX_W-1:0]] <= w_sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_p <= w_mul_a * w_mul_b;
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_i <= '0;
            end
            S_MED_LOAD: begin
                r_cand <= r_rd_data;
                r_j    <= '0;
                r_rank <= '0;
            end
            S_MED_SCAN: begin
                r_rank <= r_rank + IDX_W'(w_less);
                if (!w_scan_last) r_j <= r_j + 1'b1;
            end
            S_MED_CHECK: begin
                if (!w_rank_hit) r_i <= r_i + 1'b1;
            end
            S_RANGE: begin
                r_fault    <= w_fault;
                r_sensor   <= FAULT_TEMP;
                r_dq       <= DIV_NW'(w_prod);
                r_den      <= DIV_DW'(ADC_FULL - r_cand);
                r_rem      <= '0;
                r_div_cnt  <= '0;
                r_div_temp <= 1'b0;
            end
            S_DIV: begin
                r_rem     <= w_div_ge ? DIV_DW'(w_div_t - {1'b0, r_den})
                                      : w_div_t[DIV_DW-1:0];
                r_dq      <= {r_dq[DIV_NW-2:0], w_div_ge};
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            S_RES: begin
                r_res       <= r_dq[31:0];
                r_arg       <= LN_REF_ARG;
                r_k         <= '0;
                r_ln_sensor <= 1'b0;
                r_sensor    <= ZERO_R_TEMP;
            end
            S_NORM: begin
                if (r_arg[31]) begin
                    r_y    <= {r_arg, 31'd0};
                    r_iter <= '0;
                    r_frac <= '0;
                end else begin
                    r_arg <= r_arg << 1;
                    r_k   <= r_k + 1'b1;
                end
            end
            S_SQ1: begin
                r_acc <= 128'(r_p);
            end
            S_SQ2: begin
                r_acc <= r_acc + (128'(r_p) << 33);
            end
            S_SQ3: begin
                r_frac <= {r_frac[LOG_FRAC_W-2:0], w_ny[63]};
                r_y    <= w_ny[63] ? w_ny[63:1] : w_ny[62:0];
                r_iter <= r_iter + 1'b1;
            end
            S_LN1: begin
                r_acc <= 128'(r_p);
            end
            S_LN2, S_LN3: begin
                r_acc <= r_acc + (128'(r_p) << 32);
            end
            S_LN4: begin
                r_acc <= w_sq_sum;
            end
            S_LN5: begin
                if (r_ln_sensor) begin
                    // beta denominator, then 67600 / d by the divider
                    r_den      <= w_ln + r_c;
                    r_dq       <= TEMP_NUM;
                    r_rem      <= '0;
                    r_div_cnt  <= '0;
                    r_div_temp <= 1'b1;
                end else begin
                    // reference log done, start on the resistance
                    r_c         <= BETA_K - w_ln;
                    r_ln_sensor <= 1'b1;
                    r_arg       <= r_res;
                    r_k         <= '0;
                end
            end
            S_TEMP: begin
                r_sensor <= w_temp;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_sensor <= r_sensor;
                    r_out_final  <= w_final;
                    r_out_code   <= w_code;
                    r_out_period <= w_period;
                    r_out_fault  <= r_fault;
                end
            end
            default: ;
        endcase
    end

    // result stream
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_period, r_out_code, r_out_final, r_out_sensor};
    assign o_m_axis_tuser  = r_out_fault;

endmodule

`default_nettype wire
